@@ design/vfc_pkg.sv @@
// ----------------------------------------------------------------------------
// vfc_pkg - shared types and constants for the voxel face culling unit
// Item kinds, side codes, register indexes, face-to-tile-byte map and the
// control bundle between the sequencer and the storage block.
// ----------------------------------------------------------------------------
package vfc_pkg;

  // Input item kinds
  localparam logic [1:0] KIND_VOXEL = 2'd0;
  localparam logic [1:0] KIND_SLICE = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  // Side / face codes
  localparam logic [2:0] SIDE_TOP    = 3'd0;
  localparam logic [2:0] SIDE_BOTTOM = 3'd1;
  localparam logic [2:0] SIDE_PX     = 3'd2;
  localparam logic [2:0] SIDE_NX     = 3'd3;
  localparam logic [2:0] SIDE_PZ     = 3'd4;
  localparam logic [2:0] SIDE_NZ     = 3'd5;
  localparam int         SIDE_COUNT  = 6;

  // Configuration register indexes
  localparam logic [2:0] CFG_NEIGHBOR_PRESENT = 3'd0;
  localparam logic [2:0] CFG_TYPE_COUNT       = 3'd1;
  localparam logic [2:0] CFG_FACES_FIRST      = 3'd2;

  localparam int TILE_WORD_W = 48;

  // Byte of the type tile word that holds each face direction
  localparam logic [2:0] FACE_BYTE [SIDE_COUNT] = '{3'd2, 3'd3, 3'd4, 3'd5, 3'd0, 3'd1};

  // Storage access strobes for one cycle
  typedef struct packed {
    logic vox_wr;
    logic vox_rd;
    logic slc_wr;
    logic slc_rd;
  } mem_ctrl_t;

  // Configuration status seen by the sequencer
  typedef struct packed {
    logic [SIDE_COUNT-1:0] present;
    logic                  unknown;
  } cfg_stat_t;

endpackage

@@ design/vfc_store.sv @@
// ----------------------------------------------------------------------------
// vfc_store - voxel and boundary slice memories
// One write and one registered read port on each memory. After reset a
// clearing pass zeroes both memories; busy stays high until it finishes.
// ----------------------------------------------------------------------------
module vfc_store
  import vfc_pkg::*;
#(
  parameter int EDGE = 16
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  mem_ctrl_t                                 ctrl,
  input  logic [$clog2(EDGE*EDGE*EDGE)-1:0]         vox_waddr,
  input  logic [7:0]                                vox_wdata,
  input  logic [$clog2(EDGE*EDGE*EDGE)-1:0]         vox_raddr,
  output logic [7:0]                                vox_rdata,
  input  logic [$clog2(SIDE_COUNT*EDGE*EDGE)-1:0]   slc_waddr,
  input  logic                                      slc_wdata,
  input  logic [$clog2(SIDE_COUNT*EDGE*EDGE)-1:0]   slc_raddr,
  output logic                                      slc_rdata,
  output logic                                      busy
);

  localparam int VDEPTH  = EDGE * EDGE * EDGE;
  localparam int SDEPTH  = SIDE_COUNT * EDGE * EDGE;
  localparam int AW      = $clog2(VDEPTH);
  localparam int SW      = $clog2(SDEPTH);
  localparam int CLR_LEN = (VDEPTH > SDEPTH) ? VDEPTH : SDEPTH;
  localparam int CLW     = $clog2(CLR_LEN + 1);

  logic [7:0] vox_mem [VDEPTH];
  logic       slc_mem [SDEPTH];

  logic [CLW-1:0] clr_cnt_r;
  logic [CLW-1:0] clr_cnt_nxt;
  logic           busy_r;
  logic           busy_nxt;
  logic           vox_we;
  logic           slc_we;
  logic [AW-1:0]  vox_wa;
  logic [SW-1:0]  slc_wa;
  logic [7:0]     vox_wd;
  logic           slc_wd;
  logic [7:0]     vox_rdata_r;
  logic           slc_rdata_r;

  // Advance the clearing pass one entry a cycle
  always_comb begin
    clr_cnt_nxt = clr_cnt_r;
    busy_nxt    = busy_r;
    if (busy_r) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      if (clr_cnt_r == CLW'(CLR_LEN - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      busy_r    <= 1'b1;
    end else begin
      clr_cnt_r <= clr_cnt_nxt;
      busy_r    <= busy_nxt;
    end
  end

  // Select clearing writes over item writes
  always_comb begin
    if (busy_r) begin
      vox_we = (clr_cnt_r < CLW'(VDEPTH));
      slc_we = (clr_cnt_r < CLW'(SDEPTH));
      vox_wa = clr_cnt_r[AW-1:0];
      slc_wa = clr_cnt_r[SW-1:0];
      vox_wd = '0;
      slc_wd = 1'b0;
    end else begin
      vox_we = ctrl.vox_wr;
      slc_we = ctrl.slc_wr;
      vox_wa = vox_waddr;
      slc_wa = slc_waddr;
      vox_wd = vox_wdata;
      slc_wd = slc_wdata;
    end
  end

  // Voxel memory
  always_ff @(posedge clk) begin
    if (vox_we) begin
      vox_mem[vox_wa] <= vox_wd;
    end
    if (ctrl.vox_rd) begin
      vox_rdata_r <= vox_mem[vox_raddr];
    end
  end

  // Boundary slice memory
  always_ff @(posedge clk) begin
    if (slc_we) begin
      slc_mem[slc_wa] <= slc_wd;
    end
    if (ctrl.slc_rd) begin
      slc_rdata_r <= slc_mem[slc_raddr];
    end
  end

  assign vox_rdata = vox_rdata_r;
  assign slc_rdata = slc_rdata_r;
  assign busy      = busy_r;

endmodule

@@ design/vfc_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// vfc_cfg_regs - configuration registers and type tile lookup
// Holds neighbor presence, the registered type count and one tile word per
// type; returns the tile word and the unknown flag for a voxel type id.
// ----------------------------------------------------------------------------
module vfc_cfg_regs
  import vfc_pkg::*;
#(
  parameter int MAX_TYPES = 6
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [2:0]             cfg_index,
  input  logic [TILE_WORD_W-1:0] cfg_wdata,
  input  logic [7:0]             type_id,
  output logic [TILE_WORD_W-1:0] tile_word,
  output cfg_stat_t              stat
);

  logic [SIDE_COUNT-1:0]  present_r;
  logic [2:0]             type_count_r;
  logic [TILE_WORD_W-1:0] tab_r [MAX_TYPES];
  logic [2:0]             limit;

  // Write registers; table entries beyond MAX_TYPES are never read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r    <= '0;
      type_count_r <= '0;
      for (int i = 0; i < MAX_TYPES; i++) begin
        tab_r[i] <= '0;
      end
    end else if (cfg_wr_en) begin
      if (cfg_index == CFG_NEIGHBOR_PRESENT) begin
        present_r <= cfg_wdata[SIDE_COUNT-1:0];
      end
      if (cfg_index == CFG_TYPE_COUNT) begin
        type_count_r <= cfg_wdata[2:0];
      end
      for (int i = 0; i < MAX_TYPES; i++) begin
        if (cfg_index == CFG_FACES_FIRST + 3'(i)) begin
          tab_r[i] <= cfg_wdata;
        end
      end
    end
  end

  // Clamp the count and look up the type word
  always_comb begin
    limit        = (type_count_r > 3'(MAX_TYPES)) ? 3'(MAX_TYPES) : type_count_r;
    stat.present = present_r;
    stat.unknown = (type_id > {5'b0, limit});
    tile_word    = '0;
    for (int i = 0; i < MAX_TYPES; i++) begin
      if (!stat.unknown && type_id == 8'(i + 1)) begin
        tile_word = tab_r[i];
      end
    end
  end

endmodule

@@ design/voxel_face_culling_unit.sv @@
// ----------------------------------------------------------------------------
// voxel_face_culling_unit - hidden-face culling over one voxel chunk
//
// Input channel (in_valid / in_stall) carries load and query items. A voxel
// or boundary-bit load gives no result; loads can follow each other in every
// cycle. A query reads the center voxel and then, for each side, a voxel or
// a slice bit (none where the chunk edge has no neighbor present) through the
// single read port of each memory, one read a cycle, and then puts out one
// result a cycle while out_stall is low: one per exposed face in the order
// top, bottom, +x, -x, +z, -z, or a single result with visible low. The input
// stays stalled until the last result of a query is loaded into the output
// register.
// Result channel (out_valid / out_stall) has an output register; a stalled
// result holds and the sequencer waits. The next item is taken while the
// last result of a query still waits in the output register.
// After reset the unit clears both memories, one entry a cycle, over
// max(EDGE^3, 6*EDGE^2) entries (4096 at EDGE = 16); in_stall stays high
// meanwhile and until the sequencer leaves its clearing state. Configuration
// writes are taken at any time and should be made while the unit is idle.
// ----------------------------------------------------------------------------
module voxel_face_culling_unit
  import vfc_pkg::*;
#(
  parameter int EDGE      = 16,
  parameter int MAX_TYPES = 6
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [2:0]             cfg_index,
  input  logic [TILE_WORD_W-1:0] cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             in_kind,
  input  logic [3:0]             in_pos_x,
  input  logic [3:0]             in_pos_y,
  input  logic [3:0]             in_pos_z,
  input  logic [2:0]             in_side,
  input  logic [7:0]             in_voxel_type,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_visible,
  output logic [2:0]             out_face,
  output logic [3:0]             out_x,
  output logic [3:0]             out_y,
  output logic [3:0]             out_z,
  output logic [3:0]             out_tile_u,
  output logic [3:0]             out_tile_v,
  output logic                   out_unknown_type,
  output logic                   out_last
);

  localparam int PLANE  = EDGE * EDGE;
  localparam int VDEPTH = PLANE * EDGE;
  localparam int SDEPTH = SIDE_COUNT * PLANE;
  localparam int AW     = $clog2(VDEPTH);
  localparam int SW     = $clog2(SDEPTH);

  // Sequencer states
  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;
  localparam logic [2:0] ST_DRAIN_STEP = 3'd7;

  // Read steps and sources
  localparam logic [2:0] STEP_CENTER = 3'd0;
  localparam logic [2:0] STEP_LAST   = 3'd6;
  localparam logic [1:0] SRC_OPEN    = 2'd0;
  localparam logic [1:0] SRC_VOX     = 2'd1;
  localparam logic [1:0] SRC_SLC     = 2'd2;

  function automatic logic [SW-1:0] slice_addr(input logic [2:0] s, input logic [3:0] x,
                                               input logic [3:0] y, input logic [3:0] z);
    logic [SW-1:0] a;
    logic [SW-1:0] b;
    if (s <= SIDE_BOTTOM) begin
      a = SW'(x);
      b = SW'(z);
    end else if (s <= SIDE_NX) begin
      a = SW'(y);
      b = SW'(z);
    end else begin
      a = SW'(x);
      b = SW'(y);
    end
    return SW'(s) * SW'(PLANE) + a * SW'(EDGE) + b;
  endfunction

  logic [1:0]            state_r;
  logic [1:0]            state_nxt;
  logic [2:0]            issue_step_r;
  logic [2:0]            issue_step_nxt;
  logic [3:0]            q_x_r;
  logic [3:0]            q_y_r;
  logic [3:0]            q_z_r;
  logic                  q_inside_r;
  logic                  cap_vld_r;
  logic [2:0]            cap_step_r;
  logic [1:0]            cap_src_r;
  logic [7:0]            id_r;
  logic [SIDE_COUNT-1:0] mask_r;

  logic                  in_acc;
  logic                  in_inside;
  mem_ctrl_t             mctl;
  logic [AW-1:0]         vox_waddr;
  logic [AW-1:0]         vox_raddr;
  logic [7:0]            vox_rdata;
  logic [SW-1:0]         slc_waddr;
  logic [SW-1:0]         slc_raddr;
  logic                  slc_rdata;
  logic                  store_busy;

  logic [TILE_WORD_W-1:0] tile_word;
  cfg_stat_t             cstat;

  logic [AW-1:0]         ctr_addr;
  logic [AW-1:0]         nbr_addr [SIDE_COUNT];
  logic [SIDE_COUNT-1:0] at_edge;
  logic [2:0]            iss_side;
  logic [1:0]            iss_src;
  logic                  issue_en;
  logic [2:0]            cap_side;
  logic                  cap_exp;

  logic [SIDE_COUNT-1:0] eff;
  logic [SIDE_COUNT-1:0] rest;
  logic [2:0]            sel;
  logic [7:0]            tile_byte;
  logic                  emit_last;
  logic                  out_load;

  logic                  out_valid_r;
  logic                  out_visible_r;
  logic [2:0]            out_face_r;
  logic [3:0]            out_x_r;
  logic [3:0]            out_y_r;
  logic [3:0]            out_z_r;
  logic [3:0]            out_tile_u_r;
  logic [3:0]            out_tile_v_r;
  logic                  out_unknown_type_r;
  logic                  out_last_r;

  // Input transfer and load writes
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign in_inside = (32'(in_pos_x) < EDGE) && (32'(in_pos_y) < EDGE) &&
                     (32'(in_pos_z) < EDGE);
  assign vox_waddr = AW'(in_pos_x) + AW'(in_pos_z) * AW'(EDGE) + AW'(in_pos_y) * AW'(PLANE);
  assign slc_waddr = slice_addr(in_side, in_pos_x, in_pos_y, in_pos_z);

  // Center and neighbor addresses of the query voxel
  always_comb begin
    ctr_addr = AW'(q_x_r) + AW'(q_z_r) * AW'(EDGE) + AW'(q_y_r) * AW'(PLANE);
    nbr_addr[SIDE_TOP]    = ctr_addr + AW'(PLANE);
    nbr_addr[SIDE_BOTTOM] = ctr_addr - AW'(PLANE);
    nbr_addr[SIDE_PX]     = ctr_addr + AW'(1);
    nbr_addr[SIDE_NX]     = ctr_addr - AW'(1);
    nbr_addr[SIDE_PZ]     = ctr_addr + AW'(EDGE);
    nbr_addr[SIDE_NZ]     = ctr_addr - AW'(EDGE);
    at_edge[SIDE_TOP]     = (32'(q_y_r) == EDGE - 1);
    at_edge[SIDE_BOTTOM]  = (q_y_r == 4'd0);
    at_edge[SIDE_PX]      = (32'(q_x_r) == EDGE - 1);
    at_edge[SIDE_NX]      = (q_x_r == 4'd0);
    at_edge[SIDE_PZ]      = (32'(q_z_r) == EDGE - 1);
    at_edge[SIDE_NZ]      = (q_z_r == 4'd0);
  end

  // Issue at most one read per step: center first, then one per side
  always_comb begin
    iss_side  = issue_step_r - 3'd1;
    iss_src   = SRC_OPEN;
    issue_en  = (state_r == ST_READ) && (issue_step_r <= STEP_LAST);
    vox_raddr = ctr_addr;
    slc_raddr = slice_addr(iss_side, q_x_r, q_y_r, q_z_r);
    mctl.vox_wr = in_acc && (in_kind == KIND_VOXEL) && in_inside;
    mctl.slc_wr = in_acc && (in_kind == KIND_SLICE) && in_inside &&
                  (in_side < 3'(SIDE_COUNT));
    mctl.vox_rd = 1'b0;
    mctl.slc_rd = 1'b0;
    if (issue_en && q_inside_r) begin
      if (issue_step_r == STEP_CENTER) begin
        mctl.vox_rd = 1'b1;
        iss_src     = SRC_VOX;
      end else if (at_edge[iss_side]) begin
        if (cstat.present[iss_side]) begin
          mctl.slc_rd = 1'b1;
          iss_src     = SRC_SLC;
        end
      end else begin
        mctl.vox_rd = 1'b1;
        iss_src     = SRC_VOX;
        vox_raddr   = nbr_addr[iss_side];
      end
    end
  end

  // Exposure of the side whose read data arrives now
  always_comb begin
    cap_side = cap_step_r - 3'd1;
    case (cap_src_r)
      SRC_VOX: cap_exp = (vox_rdata == 8'd0);
      SRC_SLC: cap_exp = !slc_rdata;
      default: cap_exp = 1'b1;
    endcase
  end

  // Pick the next exposed face, lowest side first
  always_comb begin
    eff = (id_r == 8'd0) ? '0 : mask_r;
    sel = SIDE_TOP;
    for (int i = SIDE_COUNT - 1; i >= 0; i--) begin
      if (eff[i]) begin
        sel = 3'(i);
      end
    end
    rest      = eff & ~(SIDE_COUNT'(1) << sel);
    emit_last = (rest == '0);
    tile_byte = tile_word[{FACE_BYTE[sel], 3'b000} +: 8];
    out_load  = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);
  end

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    issue_step_nxt = issue_step_r;
    case (state_r)
      ST_CLEAR: begin
        if (!store_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc && in_kind == KIND_QUERY) begin
          state_nxt      = ST_READ;
          issue_step_nxt = STEP_CENTER;
        end
      end
      ST_READ: begin
        // one extra step lets the last read land before emitting
        if (issue_step_r == ST_DRAIN_STEP) begin
          state_nxt = ST_EMIT;
        end
        issue_step_nxt = issue_step_r + 3'd1;
      end
      ST_EMIT: begin
        if (out_load && emit_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      issue_step_r <= STEP_CENTER;
      cap_vld_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      issue_step_r <= issue_step_nxt;
      cap_vld_r    <= issue_en;
    end
  end

  // Latch the query and collect read results
  always_ff @(posedge clk) begin
    if (in_acc && in_kind == KIND_QUERY) begin
      q_x_r      <= in_pos_x;
      q_y_r      <= in_pos_y;
      q_z_r      <= in_pos_z;
      q_inside_r <= in_inside;
    end
    cap_step_r <= issue_step_r;
    cap_src_r  <= iss_src;
    if (cap_vld_r) begin
      if (cap_step_r == STEP_CENTER) begin
        id_r <= q_inside_r ? vox_rdata : 8'd0;
      end else begin
        mask_r[cap_side] <= cap_exp;
      end
    end else if (out_load) begin
      mask_r <= rest;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_x_r <= q_x_r;
      out_y_r <= q_y_r;
      out_z_r <= q_z_r;
      if (eff == '0) begin
        out_visible_r      <= 1'b0;
        out_face_r         <= SIDE_TOP;
        out_tile_u_r       <= 4'd0;
        out_tile_v_r       <= 4'd0;
        out_unknown_type_r <= 1'b0;
        out_last_r         <= 1'b1;
      end else begin
        out_visible_r      <= 1'b1;
        out_face_r         <= sel;
        out_tile_u_r       <= tile_byte[3:0];
        out_tile_v_r       <= tile_byte[7:4];
        out_unknown_type_r <= cstat.unknown;
        out_last_r         <= emit_last;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_visible      = out_visible_r;
  assign out_face         = out_face_r;
  assign out_x            = out_x_r;
  assign out_y            = out_y_r;
  assign out_z            = out_z_r;
  assign out_tile_u       = out_tile_u_r;
  assign out_tile_v       = out_tile_v_r;
  assign out_unknown_type = out_unknown_type_r;
  assign out_last         = out_last_r;

  vfc_store #(
    .EDGE (EDGE)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (mctl),
    .vox_waddr (vox_waddr),
    .vox_wdata (in_voxel_type),
    .vox_raddr (vox_raddr),
    .vox_rdata (vox_rdata),
    .slc_waddr (slc_waddr),
    .slc_wdata (|in_voxel_type),
    .slc_raddr (slc_raddr),
    .slc_rdata (slc_rdata),
    .busy      (store_busy)
  );

  vfc_cfg_regs #(
    .MAX_TYPES (MAX_TYPES)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .type_id   (id_r),
    .tile_word (tile_word),
    .stat      (cstat)
  );

  // No item is taken while the memories are being cleared
  a_no_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    store_busy |-> in_stall)
    else $error("input transfer during clearing pass");

  // The last side read has landed by the time emission starts
  a_mask_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ && issue_step_r == ST_DRAIN_STEP) |->
      (cap_vld_r && cap_step_r == STEP_LAST))
    else $error("emission starts before last read");

  // A query ends on the result marked last
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && emit_last) |=> (state_r == ST_IDLE))
    else $error("query did not end after last result");

  // A result with no face is always the only one
  a_hidden_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_visible_r) |-> out_last_r)
    else $error("hidden voxel result not marked last");

  // Unregistered types carry a zero tile
  a_unk_tile: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_unknown_type_r) |-> (out_tile_u_r == 4'd0 && out_tile_v_r == 4'd0))
    else $error("unknown type with nonzero tile");

endmodule
